// File: design/two_level_page_table_walker_unit_defines.svh
// ----------------------------------------------------------------------------
// Page table walker assertion macros
// Implication checks on the rising clock edge, masked while reset is high.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH

// same-cycle implication
`define PTW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ptw_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Shared widths, codes and the memory request type.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int PTW_PAGE_COUNT = 128;
  localparam int PAGE_BYTES     = 32;
  localparam int OFF_W          = 5;
  localparam int PAGE_NUM_W     = 7;
  localparam int VA_W           = 15;
  localparam int PA_W           = 12;
  localparam int BYTE_W         = 8;
  localparam int STATUS_W       = 2;
  localparam int ENTRY_VALID    = 7;
  localparam int TIDX_LSB       = 5;
  localparam int DIDX_LSB       = 10;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_XLATE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_DIR_FAULT = 2'd1,
    ST_TBL_FAULT = 2'd2
  } status_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [PA_W-1:0]   addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

endpackage

// File: design/ptw_req_if.sv
// ----------------------------------------------------------------------------
// Page table walker request channel
// Valid/ready channel carrying one load or translate request.
// ----------------------------------------------------------------------------
interface ptw_req_if
  import ptw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [PA_W-1:0]   load_addr;
  logic [BYTE_W-1:0] load_byte;
  logic [VA_W-1:0]   virt_addr;

  modport source (output valid, req_type, load_addr, load_byte, virt_addr, input ready);
  modport sink   (input valid, req_type, load_addr, load_byte, virt_addr, output ready);
endinterface

// File: design/ptw_rsp_if.sv
// ----------------------------------------------------------------------------
// Page table walker response channel
// Valid/ready channel carrying one translation result.
// ----------------------------------------------------------------------------
interface ptw_rsp_if
  import ptw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [VA_W-1:0]     virt_addr_echo;
  logic [PA_W-1:0]     phys_addr;
  logic [BYTE_W-1:0]   data_byte;
  logic [STATUS_W-1:0] status;

  modport source (output valid, virt_addr_echo, phys_addr, data_byte, status, input ready);
  modport sink   (input valid, virt_addr_echo, phys_addr, data_byte, status, output ready);
endinterface

// File: design/two_level_page_table_walker_unit.sv
// ----------------------------------------------------------------------------
// Two-level page table walker
// Byte memory of pages with a directory/table walk per translate request.
//
//   channel  dir  handshake     contents
//   req      in   valid/ready   req_type, load_addr, load_byte, virt_addr
//   rsp      out  valid/ready   virt_addr_echo, phys_addr, data_byte, status
//   cfg      in   cfg_we        cfg_wdata -> directory base page
//
// A load request gives no response.
// A translate request makes three dependent reads of the single memory port
// (directory, table and data), each read registered; faults end the walk early
// but still pass through the response stage.
// The response register holds while rsp.ready is low; a finished walk waits in
// its last state and the request input stalls until the response is taken.
// Synchronous reset clears the sequencer and response valid; memory is not cleared.
// ----------------------------------------------------------------------------
`include "two_level_page_table_walker_unit_defines.svh"

module two_level_page_table_walker_unit
  import ptw_pkg::*;
#(
  parameter int PAGE_COUNT = PTW_PAGE_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [PAGE_NUM_W-1:0] cfg_wdata,
  ptw_req_if.sink               req,
  ptw_rsp_if.source             rsp
);

  localparam int PG_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int MEM_AW = PG_W + OFF_W;
  localparam int DEPTH  = PAGE_COUNT * PAGE_BYTES;

  logic [PAGE_NUM_W-1:0] base_page;
  mem_req_t              mreq;
  logic [BYTE_W-1:0]     rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_page <= '0;
    end else if (cfg_we) begin
      base_page <= cfg_wdata;
    end
  end

  ptw_walk #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .base_page (base_page),
    .req       (req),
    .rsp       (rsp),
    .mreq      (mreq),
    .rd_data   (rd_data)
  );

  ptw_mem #(
    .AW    (MEM_AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  `PTW_ASSERT_SAME(a_wr_only_on_load, clk, rst, mreq.we, req.valid && req.ready && req.req_type == REQ_LOAD, "memory write without an accepted load")
  `PTW_ASSERT_SAME(a_xlate_reads_dir, clk, rst, req.valid && req.ready && req.req_type == REQ_XLATE, mreq.re && !mreq.we, "translate accepted without directory read")
  `PTW_ASSERT_SAME(a_fault_zero, clk, rst, rsp.valid && rsp.status != ST_OK, rsp.phys_addr == '0 && rsp.data_byte == '0, "faulted response carries nonzero address or data")
  `PTW_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.virt_addr_echo) && $stable(rsp.status), "stalled response changed")

endmodule

// File: design/ptw_mem.sv
// ----------------------------------------------------------------------------
// Page table walker physical memory
// Single-port byte memory with a registered read.
// ----------------------------------------------------------------------------
module ptw_mem
  import ptw_pkg::*;
#(
  parameter int AW    = PA_W,
  parameter int DEPTH = PTW_PAGE_COUNT * PAGE_BYTES
) (
  input  logic              clk,
  input  mem_req_t          mreq,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.addr[AW-1:0]] <= mreq.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.re) begin
      rd_data <= mem[mreq.addr[AW-1:0]];
    end
  end

endmodule

// File: design/ptw_walk.sv
// ----------------------------------------------------------------------------
// Page table walker sequencer
// Issues load writes and directory, table and data reads and registers the result.
// ----------------------------------------------------------------------------
module ptw_walk
  import ptw_pkg::*;
#(
  parameter int PAGE_COUNT = PTW_PAGE_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [PAGE_NUM_W-1:0] base_page,
  ptw_req_if.sink               req,
  ptw_rsp_if.source             rsp,
  output mem_req_t              mreq,
  input  logic [BYTE_W-1:0]     rd_data
);

  localparam int PG_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int WRAP_N = 1 << PAGE_NUM_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIR  = 4'b0010,
    S_TBL  = 4'b0100,
    S_DAT  = 4'b1000
  } state_t;

  state_t              st, st_next;
  logic [VA_W-1:0]     va, va_next;
  logic [PA_W-1:0]     pa, pa_next;
  status_t             stat, stat_next;

  logic                rsp_valid, rsp_valid_next;
  logic [VA_W-1:0]     rsp_va;
  logic [PA_W-1:0]     rsp_pa;
  logic [BYTE_W-1:0]   rsp_data;
  status_t             rsp_status;

  logic                acc;
  logic                out_free;
  logic                out_load;
  logic [PG_W-1:0]     wrap_tab [WRAP_N];

  for (genvar i = 0; i < WRAP_N; i++) begin : g_wrap
    assign wrap_tab[i] = PG_W'(i % PAGE_COUNT);
  end

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (st == S_IDLE) || ((st == S_DAT) && out_free);
  assign acc       = req.valid && req.ready;
  assign out_load  = (st == S_DAT) && out_free;

  always_comb begin
    st_next        = st;
    va_next        = va;
    pa_next        = pa;
    stat_next      = stat;
    rsp_valid_next = rsp_valid;
    mreq           = '0;

    if (rsp.valid && rsp.ready) begin
      rsp_valid_next = 1'b0;
    end

    if (acc) begin
      if (req.req_type == REQ_LOAD) begin
        mreq.we    = 1'b1;
        mreq.addr  = PA_W'({wrap_tab[req.load_addr[PA_W-1:OFF_W]],
                            req.load_addr[OFF_W-1:0]});
        mreq.wdata = req.load_byte;
      end else begin
        mreq.re   = 1'b1;
        mreq.addr = PA_W'({wrap_tab[base_page],
                           req.virt_addr[DIDX_LSB +: OFF_W]});
      end
    end

    case (st)
      S_IDLE: begin
        if (acc && req.req_type == REQ_XLATE) begin
          st_next   = S_DIR;
          va_next   = req.virt_addr;
          stat_next = ST_OK;
        end
      end
      S_DIR: begin
        if (rd_data[ENTRY_VALID]) begin
          mreq.re   = 1'b1;
          mreq.addr = PA_W'({wrap_tab[rd_data[PAGE_NUM_W-1:0]], va[TIDX_LSB +: OFF_W]});
          st_next   = S_TBL;
        end else begin
          stat_next = ST_DIR_FAULT;
          st_next   = S_DAT;
        end
      end
      S_TBL: begin
        if (rd_data[ENTRY_VALID]) begin
          mreq.re   = 1'b1;
          mreq.addr = PA_W'({wrap_tab[rd_data[PAGE_NUM_W-1:0]], va[OFF_W-1:0]});
          pa_next   = {rd_data[PAGE_NUM_W-1:0], va[OFF_W-1:0]};
        end else begin
          stat_next = ST_TBL_FAULT;
        end
        st_next = S_DAT;
      end
      S_DAT: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          if (acc && req.req_type == REQ_XLATE) begin
            st_next   = S_DIR;
            va_next   = req.virt_addr;
            stat_next = ST_OK;
          end else begin
            st_next = S_IDLE;
          end
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      st        <= st_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    va   <= va_next;
    pa   <= pa_next;
    stat <= stat_next;
    if (out_load) begin
      rsp_va     <= va;
      rsp_status <= stat;
      if (stat == ST_OK) begin
        rsp_pa   <= pa;
        rsp_data <= rd_data;
      end else begin
        rsp_pa   <= '0;
        rsp_data <= '0;
      end
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.virt_addr_echo = rsp_va;
  assign rsp.phys_addr      = rsp_pa;
  assign rsp.data_byte      = rsp_data;
  assign rsp.status         = rsp_status;

endmodule
